// ----- hw/rtl/seven_segment_two_wire_sender_defines.svh -----
// Assertion helpers shared by the sender's modules.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef SEVEN_SEGMENT_TWO_WIRE_SENDER_DEFINES_SVH
`define SEVEN_SEGMENT_TWO_WIRE_SENDER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SSTS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SSTS_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ssts_pkg.sv -----
package ssts_pkg;

    // Number of grid positions written by an auto-increment update.
    localparam int DIGIT_COUNT = 4;
    // Digit codes carried by one request.
    localparam int INPUT_DIGITS = 4;
    // Decimal places produced from the 14-bit value (units first).
    localparam int DEC_DIGITS = 6;

    // Longest address-plus-segments frame.
    localparam int FRAME_LEN_MAX = 1 + DIGIT_COUNT;
    localparam int BYTE_IDX_W = $clog2(FRAME_LEN_MAX);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration data width (widest register).
    localparam int CFG_DATA_W = 3;

    // Command bytes on the wire.
    localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
    localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
    localparam logic [7:0] CMD_ADDR_BASE = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
    localparam logic [7:0] SEG_POINT = 8'h80;

    // Hex digit to segment pattern.
    localparam logic [7:0] SEG_TABLE [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_SINGLE  = 2'd1,
        MODE_DIGITS  = 2'd2,
        MODE_DECIMAL = 2'd3
    } mode_t;

    typedef enum logic {
        FRAME_FIXED = 1'b0,
        FRAME_AUTO  = 1'b1
    } frame_kind_t;

    typedef enum logic {
        REG_BRIGHTNESS  = 1'b0,
        REG_CLOCK_POINT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        TX_DATA_CMD     = 2'd0,
        TX_ADDR_SEGS    = 2'd1,
        TX_DISPLAY_CTRL = 2'd2
    } tx_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_BIT_LO = 4'd2,
        PH_BIT_HI = 4'd3,
        PH_ACK_LO = 4'd4,
        PH_ACK_HI = 4'd5,
        PH_END0   = 4'd6,
        PH_END1   = 4'd7,
        PH_END2   = 4'd8
    } phase_t;

    // Configuration seen by the front and the back.
    typedef struct packed {
        logic [2:0] brightness;
        logic       clock_point;
    } cfg_t;

    // One classified item waiting for the wire sequencer.
    typedef struct packed {
        logic                        is_tick;
        frame_kind_t                 frame_kind;
        logic [7:0]                  addr_byte;
        logic [DIGIT_COUNT-1:0][7:0] seg;
    } queue_entry_t;

    // Digit code to segment byte, with blanking and the clock point.
    function automatic logic [7:0] encode_digit(input logic [7:0] code, input logic raw,
                                                input logic blank, input logic point);
        logic [7:0] s;
        begin
            if (blank)
                s = 8'h00;
            else if (raw)
                s = code;
            else if (code[7:4] == 4'h0)
                s = SEG_TABLE[code[3:0]];
            else
                s = 8'h00;
            if (point)
                s = s | SEG_POINT;
            return s;
        end
    endfunction

endpackage

// ----- hw/rtl/ssts_if.sv -----
// Request and tick channel.
interface ssts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        raw_segments;
    logic [2:0]  digit_addr;
    logic        force_blank;
    logic [7:0]  digit_0;
    logic [7:0]  digit_1;
    logic [7:0]  digit_2;
    logic [7:0]  digit_3;
    logic [13:0] decimal_value;

    modport source (output valid, mode, raw_segments, digit_addr, force_blank,
                    digit_0, digit_1, digit_2, digit_3, decimal_value,
                    input ready);
    modport sink (input valid, mode, raw_segments, digit_addr, force_blank,
                  digit_0, digit_1, digit_2, digit_3, decimal_value,
                  output ready);
endinterface

// Pin level channel.
interface ssts_out_if;
    logic valid;
    logic ready;
    logic clk_level;
    logic dio_level;
    logic busy_res;

    modport source (output valid, clk_level, dio_level, busy_res, input ready);
    modport sink (input valid, clk_level, dio_level, busy_res, output ready);
endinterface

// ----- hw/rtl/ssts_front.sv -----
module ssts_front (
    input  logic                  clk,
    input  logic                  rst_n,
    ssts_in_if.sink               item,
    input  ssts_pkg::cfg_t        cfg,
    input  logic                  full,
    output logic                  push,
    output ssts_pkg::queue_entry_t push_entry
);
    import ssts_pkg::*;

    logic        a_valid_reg;
    mode_t       mode_reg;
    logic        raw_reg;
    logic [2:0]  addr_reg;
    logic        blank_reg;
    logic [7:0]  digit_reg [INPUT_DIGITS];
    logic [13:0] value_reg;
    logic [10:0] q1_reg;
    logic [7:0]  q2_reg;
    logic [4:0]  q3_reg;

    logic [30:0] prod1;
    logic [26:0] prod2;
    logic [27:0] prod3;
    logic        accept;

    logic [13:0] rem0;
    logic [10:0] rem1;
    logic [7:0]  rem2;
    logic        q4;
    logic [4:0]  rem3;
    logic [3:0]  dec [DEC_DIGITS];

    // The stage moves on whenever the queue has room.
    assign item.ready = !a_valid_reg || !full;
    assign accept = item.valid && item.ready;
    assign push = a_valid_reg && !full;

    // Reciprocal products for value/10, value/100 and value/1000.
    assign prod1 = 31'(item.decimal_value) * 31'(17'd52429);
    assign prod2 = 27'(item.decimal_value) * 27'(13'd5243);
    assign prod3 = 28'(item.decimal_value) * 28'(14'd8389);

    // Input stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (accept)
            a_valid_reg <= 1'b1;
        else if (push)
            a_valid_reg <= 1'b0;
    end

    // Input stage payload and quotients.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode_t'(item.mode);
            raw_reg      <= item.raw_segments;
            addr_reg     <= item.digit_addr;
            blank_reg    <= item.force_blank;
            digit_reg[0] <= item.digit_0;
            digit_reg[1] <= item.digit_1;
            digit_reg[2] <= item.digit_2;
            digit_reg[3] <= item.digit_3;
            value_reg    <= item.decimal_value;
            q1_reg       <= prod1[29:19];
            q2_reg       <= prod2[26:19];
            q3_reg       <= prod3[27:23];
        end
    end

    // Decimal places from neighboring quotients.
    always_comb
    begin
        rem0 = value_reg - (14'(q1_reg) << 3) - (14'(q1_reg) << 1);
        rem1 = q1_reg - (11'(q2_reg) << 3) - (11'(q2_reg) << 1);
        rem2 = q2_reg - (8'(q3_reg) << 3) - (8'(q3_reg) << 1);
        q4 = (q3_reg >= 5'd10);
        rem3 = q4 ? (q3_reg - 5'd10) : q3_reg;
        dec[0] = rem0[3:0];
        dec[1] = rem1[3:0];
        dec[2] = rem2[3:0];
        dec[3] = rem3[3:0];
        dec[4] = {3'b000, q4};
        dec[5] = 4'd0;
    end

    // Classify the item and build its frame bytes.
    always_comb
    begin
        push_entry.is_tick = (mode_reg == MODE_TICK);
        push_entry.frame_kind = (mode_reg == MODE_SINGLE) ? FRAME_FIXED : FRAME_AUTO;
        push_entry.addr_byte = (mode_reg == MODE_SINGLE) ?
                               (CMD_ADDR_BASE | {5'b00000, addr_reg}) : CMD_ADDR_BASE;
        for (int j = 0; j < DIGIT_COUNT; j++)
        begin
            case (mode_reg)
                MODE_SINGLE:
                    push_entry.seg[j] = (j == 0) ?
                        encode_digit(digit_reg[0], raw_reg, blank_reg, cfg.clock_point) :
                        8'h00;
                MODE_DIGITS:
                    if (j < INPUT_DIGITS)
                        push_entry.seg[j] = encode_digit(digit_reg[j % INPUT_DIGITS],
                                                         raw_reg, 1'b0, cfg.clock_point);
                    else
                        push_entry.seg[j] = encode_digit(8'h00, 1'b0, 1'b1,
                                                         cfg.clock_point);
                MODE_DECIMAL:
                    push_entry.seg[j] = encode_digit({4'h0, dec[DIGIT_COUNT - 1 - j]},
                                                     1'b0, 1'b0, cfg.clock_point);
                default:
                    push_entry.seg[j] = 8'h00;
            endcase
        end
    end

endmodule

// ----- hw/rtl/ssts_queue.sv -----
`include "seven_segment_two_wire_sender_defines.svh"

module ssts_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ssts_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output ssts_pkg::queue_entry_t head,
    output logic                   head_valid
);
    import ssts_pkg::*;

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

    // Fill level.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers and level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `SSTS_ASSERT(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue level overflow")
    `SSTS_ASSERT(a_pop_nonempty, pop |-> count_reg != '0, "pop from an empty queue")
    `SSTS_ASSERT_NEXT(a_push_level, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue level lost a push")

endmodule

// ----- hw/rtl/ssts_back.sv -----
`include "seven_segment_two_wire_sender_defines.svh"

module ssts_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssts_pkg::cfg_t         cfg,
    input  ssts_pkg::queue_entry_t head,
    input  logic                   head_valid,
    output logic                   pop,
    ssts_out_if.source             result
);
    import ssts_pkg::*;

    phase_t                phase_reg;
    phase_t                phase_next;
    tx_t                   tx_reg;
    tx_t                   tx_next;
    logic [BYTE_IDX_W-1:0] byte_index_reg;
    logic [BYTE_IDX_W-1:0] byte_index_next;
    logic [2:0]            bit_index_reg;
    logic [2:0]            bit_index_next;
    frame_kind_t           frame_kind_reg;
    logic [7:0]            frame_reg [FRAME_LEN_MAX];
    logic [7:0]            control_reg;

    logic                  res_valid_reg;
    logic                  clk_level_reg;
    logic                  dio_level_reg;
    logic                  busy_res_reg;

    logic                  out_free;
    logic                  tick_go;
    logic                  req_go;
    logic [7:0]            cur_byte;
    logic                  cur_bit;
    logic [BYTE_IDX_W:0]   byte_count;
    logic [BYTE_IDX_W:0]   frame_len;
    logic                  clk_lvl;
    logic                  dio_lvl;

    // A tick needs room in the output register; a request never does.
    assign out_free = !res_valid_reg || result.ready;
    assign pop = head_valid && (!head.is_tick || out_free);
    assign tick_go = pop && head.is_tick;
    assign req_go = pop && !head.is_tick && (phase_reg == PH_IDLE);

    // Byte on the wire and its current bit, LSB first.
    always_comb
    begin
        case (tx_reg)
            TX_DATA_CMD:
                cur_byte = (frame_kind_reg == FRAME_AUTO) ? CMD_DATA_AUTO : CMD_DATA_FIXED;
            TX_ADDR_SEGS:
                cur_byte = frame_reg[byte_index_reg];
            default:
                cur_byte = control_reg;
        endcase
        cur_bit = cur_byte[bit_index_reg];
    end

    assign byte_count = {1'b0, byte_index_reg} + 1'b1;
    assign frame_len = (tx_reg != TX_ADDR_SEGS) ? (BYTE_IDX_W + 1)'(1) :
                       (frame_kind_reg == FRAME_AUTO) ? (BYTE_IDX_W + 1)'(FRAME_LEN_MAX) :
                       (BYTE_IDX_W + 1)'(2);

    // Sequencer next state.
    always_comb
    begin
        phase_next = phase_reg;
        tx_next = tx_reg;
        byte_index_next = byte_index_reg;
        bit_index_next = bit_index_reg;
        if (req_go)
        begin
            phase_next = PH_START;
            tx_next = TX_DATA_CMD;
            byte_index_next = '0;
            bit_index_next = '0;
        end
        else if (tick_go)
        begin
            case (phase_reg)
                PH_START:
                begin
                    bit_index_next = '0;
                    phase_next = PH_BIT_LO;
                end
                PH_BIT_LO:
                    phase_next = PH_BIT_HI;
                PH_BIT_HI:
                begin
                    bit_index_next = bit_index_reg + 1'b1;
                    phase_next = (bit_index_reg == 3'd7) ? PH_ACK_LO : PH_BIT_LO;
                end
                PH_ACK_LO:
                    phase_next = PH_ACK_HI;
                PH_ACK_HI:
                begin
                    if (byte_count < frame_len)
                    begin
                        byte_index_next = byte_count[BYTE_IDX_W-1:0];
                        bit_index_next = '0;
                        phase_next = PH_BIT_LO;
                    end
                    else
                    begin
                        phase_next = PH_END0;
                    end
                end
                PH_END0:
                    phase_next = PH_END1;
                PH_END1:
                    phase_next = PH_END2;
                PH_END2:
                begin
                    byte_index_next = '0;
                    bit_index_next = '0;
                    if (tx_reg == TX_DISPLAY_CTRL)
                    begin
                        tx_next = TX_DATA_CMD;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        tx_next = tx_t'(tx_reg + 1'b1);
                        phase_next = PH_START;
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // Pin levels for the current phase.
    always_comb
    begin
        case (phase_reg)
            PH_START:
            begin
                clk_lvl = 1'b1;
                dio_lvl = 1'b0;
            end
            PH_BIT_LO:
            begin
                clk_lvl = 1'b0;
                dio_lvl = cur_bit;
            end
            PH_BIT_HI:
            begin
                clk_lvl = 1'b1;
                dio_lvl = cur_bit;
            end
            PH_ACK_LO:
            begin
                clk_lvl = 1'b0;
                dio_lvl = 1'b1;
            end
            PH_ACK_HI:
            begin
                clk_lvl = 1'b1;
                dio_lvl = 1'b0;
            end
            PH_END0:
            begin
                clk_lvl = 1'b0;
                dio_lvl = 1'b0;
            end
            PH_END1:
            begin
                clk_lvl = 1'b1;
                dio_lvl = 1'b0;
            end
            default:
            begin
                clk_lvl = 1'b1;
                dio_lvl = 1'b1;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tx_reg         <= TX_DATA_CMD;
            byte_index_reg <= '0;
            bit_index_reg  <= '0;
            frame_kind_reg <= FRAME_FIXED;
        end
        else
        begin
            phase_reg      <= phase_next;
            tx_reg         <= tx_next;
            byte_index_reg <= byte_index_next;
            bit_index_reg  <= bit_index_next;
            if (req_go)
                frame_kind_reg <= head.frame_kind;
        end
    end

    // Frame bytes and control byte, latched when an update starts.
    always_ff @(posedge clk)
    begin
        if (req_go)
        begin
            frame_reg[0] <= head.addr_byte;
            for (int k = 1; k < FRAME_LEN_MAX; k++)
                frame_reg[k] <= head.seg[k - 1];
            control_reg <= CMD_DISPLAY_ON | {5'b00000, cfg.brightness};
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (tick_go)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            clk_level_reg <= clk_lvl;
            dio_level_reg <= dio_lvl;
            busy_res_reg  <= (phase_next != PH_IDLE);
        end
    end

    assign result.valid = res_valid_reg;
    assign result.clk_level = clk_level_reg;
    assign result.dio_level = dio_level_reg;
    assign result.busy_res = busy_res_reg;

    `SSTS_ASSERT_NEXT(a_req_starts, req_go, phase_reg == PH_START, "update did not start")
    `SSTS_ASSERT_NEXT(a_tick_result, tick_go, res_valid_reg, "tick lost its result")
    `SSTS_ASSERT(a_byte_range, byte_index_reg <= BYTE_IDX_W'(FRAME_LEN_MAX - 1), "byte index past frame")
    `SSTS_ASSERT(a_idle_tx, (phase_reg == PH_IDLE) |-> (tx_reg == TX_DATA_CMD), "idle with a transaction open")

endmodule

// ----- hw/rtl/seven_segment_two_wire_sender.sv -----
// Channel   Role    Transfer when          Payload
// item      sink    valid && ready         mode, digit codes, decimal value
// result    source  valid && ready         clk_level, dio_level, busy_res
// wr_*      write   wr_en high             register index, data
//
// One item is taken per clock while the queue has room. A tick's pin levels pass
// through the input stage, the four-entry queue and the output register. The wire
// sequencer steps one phase per tick; it pops one queued item per clock, but a tick
// only while the output register has room. Reset sets brightness to 3 and clears the
// clock point; no clearing pass is run. A stalled result backs up into the queue and
// then the input; a request at the queue head never waits on the result channel.
module seven_segment_two_wire_sender (
    input  logic                             clk,
    input  logic                             rst_n,
    ssts_in_if.sink                          item,
    ssts_out_if.source                       result,
    input  logic                             wr_en,
    input  ssts_pkg::reg_index_t             wr_index,
    input  logic [ssts_pkg::CFG_DATA_W-1:0]  wr_data
);
    import ssts_pkg::*;

    logic [2:0]   brightness_reg;
    logic         clock_point_reg;
    cfg_t         cfg;

    logic         push;
    logic         full;
    logic         pop;
    logic         head_valid;
    queue_entry_t push_entry;
    queue_entry_t head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= 3'd3;
            clock_point_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BRIGHTNESS:  brightness_reg  <= wr_data[2:0];
                REG_CLOCK_POINT: clock_point_reg <= wr_data[0];
                default:         ;
            endcase
        end
    end

    assign cfg.brightness = brightness_reg;
    assign cfg.clock_point = clock_point_reg;

    ssts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg        (cfg),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    ssts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    ssts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ----- tb/tb_seven_segment_two_wire_sender.sv -----
module tb_seven_segment_two_wire_sender;
    timeunit 1ns;
    timeprecision 1ps;

    import ssts_pkg::*;

    // One item as offered on the request channel; codes[0] is the leftmost digit.
    typedef struct packed {
        mode_t           mode;
        logic            raw;
        logic [2:0]      addr;
        logic            blank;
        logic [3:0][7:0] codes;
        logic [13:0]     value;
    } request_t;

    // Pin levels carried by one result transfer.
    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy;
    } pin_levels_t;

    // Tracks the wire sequencer and holds the pin levels still to arrive.
    class waveform_scoreboard;
        logic [2:0]  brightness;
        logic        clock_point;
        logic [7:0]  frame_data [1 + DIGIT_COUNT];
        phase_t      phase;
        int          byte_pos;
        int          bit_pos;
        tx_t         frame_no;
        frame_kind_t kind;
        logic [7:0]  ctrl_byte;
        pin_levels_t levels_due [$];
        int          mismatches;
        int          checked;
        int          updates;
        int          ignored;
        int          ticks;

        function new();
            brightness = 3'd3;
            clock_point = 1'b0;
            foreach (frame_data[i])
                frame_data[i] = 8'h00;
            phase = PH_IDLE;
            byte_pos = 0;
            bit_pos = 0;
            frame_no = TX_DATA_CMD;
            kind = FRAME_FIXED;
            ctrl_byte = CMD_DISPLAY_ON | 8'h03;
            mismatches = 0;
            checked = 0;
            updates = 0;
            ignored = 0;
            ticks = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [2:0] data);
            if (idx == REG_BRIGHTNESS)
                brightness = data;
            else
                clock_point = data[0];
        endfunction

        // Digit code to segment pattern, with blanking and the clock point.
        function logic [7:0] segment_byte(logic [7:0] code, logic raw, logic blank);
            logic [7:0] s;
            s = 8'h00;
            if (!blank)
                s = raw ? code : ((code < 8'd16) ? SEG_TABLE[code[3:0]] : 8'h00);
            return clock_point ? (s | SEG_POINT) : s;
        endfunction

        function logic [7:0] wire_byte();
            case (frame_no)
                TX_DATA_CMD:  return (kind == FRAME_AUTO) ? CMD_DATA_AUTO : CMD_DATA_FIXED;
                TX_ADDR_SEGS: return frame_data[byte_pos];
                default:      return ctrl_byte;
            endcase
        endfunction

        function int frame_length();
            if (frame_no == TX_ADDR_SEGS)
                return (kind == FRAME_AUTO) ? 1 + DIGIT_COUNT : 2;
            return 1;
        endfunction

        // Advances the sequencer by one tick and returns the pin levels it drives.
        function pin_levels_t step_waveform();
            pin_levels_t lv;
            logic [7:0]  cur;
            lv.clk_level = 1'b1;
            lv.dio_level = 1'b1;
            case (phase)
                PH_START:
                begin
                    lv.dio_level = 1'b0;
                    bit_pos = 0;
                    phase = PH_BIT_LO;
                end
                PH_BIT_LO:
                begin
                    cur = wire_byte();
                    lv.clk_level = 1'b0;
                    lv.dio_level = cur[bit_pos];
                    phase = PH_BIT_HI;
                end
                PH_BIT_HI:
                begin
                    cur = wire_byte();
                    lv.dio_level = cur[bit_pos];
                    bit_pos++;
                    phase = (bit_pos >= 8) ? PH_ACK_LO : PH_BIT_LO;
                end
                PH_ACK_LO:
                begin
                    lv.clk_level = 1'b0;
                    phase = PH_ACK_HI;
                end
                PH_ACK_HI:
                begin
                    lv.dio_level = 1'b0;
                    byte_pos++;
                    if (byte_pos < frame_length())
                    begin
                        bit_pos = 0;
                        phase = PH_BIT_LO;
                    end
                    else
                        phase = PH_END0;
                end
                PH_END0:
                begin
                    lv.clk_level = 1'b0;
                    lv.dio_level = 1'b0;
                    phase = PH_END1;
                end
                PH_END1:
                begin
                    lv.dio_level = 1'b0;
                    phase = PH_END2;
                end
                PH_END2:
                begin
                    byte_pos = 0;
                    bit_pos = 0;
                    if (frame_no == TX_DISPLAY_CTRL)
                    begin
                        frame_no = TX_DATA_CMD;
                        phase = PH_IDLE;
                    end
                    else
                    begin
                        frame_no = tx_t'(frame_no + 2'd1);
                        phase = PH_START;
                    end
                end
                default:
                    phase = PH_IDLE;
            endcase
            lv.busy = (phase != PH_IDLE);
            return lv;
        endfunction

        // Called for every accepted item transfer.
        function void note_item(request_t r);
            int v;
            if (r.mode == MODE_TICK)
            begin
                ticks++;
                levels_due.push_back(step_waveform());
                return;
            end
            // A request during an update is dropped.
            if (phase != PH_IDLE)
            begin
                ignored++;
                return;
            end
            updates++;
            frame_data[0] = CMD_ADDR_BASE;
            case (r.mode)
                MODE_SINGLE:
                begin
                    kind = FRAME_FIXED;
                    frame_data[0] = CMD_ADDR_BASE | {5'b0, r.addr};
                    frame_data[1] = segment_byte(r.codes[0], r.raw, r.blank);
                end
                MODE_DIGITS:
                begin
                    kind = FRAME_AUTO;
                    for (int k = 0; k < DIGIT_COUNT; k++)
                        frame_data[1 + k] = (k < 4) ? segment_byte(r.codes[k], r.raw, 1'b0)
                                                    : segment_byte(8'h00, 1'b0, 1'b1);
                end
                default:
                begin
                    // Units go to the rightmost position; higher places wrap.
                    kind = FRAME_AUTO;
                    v = int'(r.value);
                    for (int k = DIGIT_COUNT; k > 0; k--)
                    begin
                        frame_data[k] = segment_byte(8'(v % 10), 1'b0, 1'b0);
                        v = v / 10;
                    end
                end
            endcase
            ctrl_byte = CMD_DISPLAY_ON | {5'b0, brightness};
            frame_no = TX_DATA_CMD;
            byte_pos = 0;
            bit_pos = 0;
            phase = PH_START;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        // Called for every accepted result transfer.
        function void check_result(pin_levels_t got);
            pin_levels_t want;
            if (levels_due.size() == 0)
            begin
                flag($sformatf("Unexpected result: clk %b dio %b busy %b",
                               got.clk_level, got.dio_level, got.busy));
                return;
            end
            want = levels_due.pop_front();
            if (got.clk_level !== want.clk_level)
                flag($sformatf("Result %0d clk_level: expected %b, got %b",
                               checked, want.clk_level, got.clk_level));
            if (got.dio_level !== want.dio_level)
                flag($sformatf("Result %0d dio_level: expected %b, got %b",
                               checked, want.dio_level, got.dio_level));
            if (got.busy !== want.busy)
                flag($sformatf("Result %0d busy_res: expected %b, got %b",
                               checked, want.busy, got.busy));
            checked++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    reg_index_t            wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    ssts_in_if  item_ch ();
    ssts_out_if result_ch ();

    seven_segment_two_wire_sender dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    waveform_scoreboard sb;
    bit                 sender_eager;
    int                 hold_asks;
    int                 holds_done;
    int                 config_changes;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results still expected", sb.levels_due.size());
        $display("FAIL");
        $finish;
    end

    function automatic request_t random_request();
        request_t r;
        r.mode = mode_t'($urandom_range(1, 3));
        r.raw = 1'($urandom_range(0, 1));
        r.addr = 3'($urandom_range(0, 7));
        r.blank = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < 4; k++)
            r.codes[k] = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        r.value = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 9999));
        return r;
    endfunction

    function automatic request_t random_tick();
        request_t r;
        r = random_request();
        r.mode = MODE_TICK;
        return r;
    endfunction

    function automatic request_t make_req(mode_t mode, logic raw, logic [2:0] addr,
                                          logic blank, logic [31:0] codes,
                                          logic [13:0] value);
        request_t r;
        r.mode = mode;
        r.raw = raw;
        r.addr = addr;
        r.blank = blank;
        r.codes = codes;
        r.value = value;
        return r;
    endfunction

    // Offers one item and returns at the edge of its transfer; valid is left high.
    task automatic send(request_t r);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.mode <= r.mode;
        item_ch.raw_segments <= r.raw;
        item_ch.digit_addr <= r.addr;
        item_ch.force_blank <= r.blank;
        item_ch.digit_0 <= r.codes[0];
        item_ch.digit_1 <= r.codes[1];
        item_ch.digit_2 <= r.codes[2];
        item_ch.digit_3 <= r.codes[3];
        item_ch.decimal_value <= r.value;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(r);
    endtask

    // One request, the ticks that carry its update out, and a few idle ticks.
    // With noise, a request may also be offered while the update is in flight.
    task automatic run_update(request_t r, bit noisy, bit eager);
        int noise_at;
        int k;
        sender_eager = eager;
        noise_at = noisy ? $urandom_range(0, 120) : -1;
        send(r);
        k = 0;
        while (sb.phase != PH_IDLE)
        begin
            if (k == noise_at)
                send(random_request());
            send(random_tick());
            k++;
        end
        repeat ($urandom_range(0, 3))
            send(random_tick());
    endtask

    // Stops offering items until every expected result has come, plus a margin.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.levels_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic reconfigure(logic [2:0] level, logic point);
        logic [2:0] point_word;
        point_word = {2'($urandom), point};
        drain();
        wr_en <= 1'b1;
        wr_index <= REG_BRIGHTNESS;
        wr_data <= level;
        sb.write_reg(REG_BRIGHTNESS, level);
        @(posedge clk);
        wr_index <= REG_CLOCK_POINT;
        wr_data <= point_word;
        sb.write_reg(REG_CLOCK_POINT, point_word);
        @(posedge clk);
        wr_en <= 1'b0;
        config_changes++;
    endtask

    // Result side: random stalls, eager stretches and one long hold on request.
    initial
    begin : receiver
        int          stall;
        int          count;
        bit          receiver_eager;
        pin_levels_t got;
        count = 0;
        receiver_eager = 1'b0;
        result_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (count % 40 == 0)
                receiver_eager = ($urandom_range(0, 3) == 0);
            if (hold_asks > holds_done)
            begin
                holds_done++;
                stall = 300;
            end
            else
                stall = receiver_eager ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got = {result_ch.clk_level, result_ch.dio_level, result_ch.busy_res};
            sb.check_result(got);
            count++;
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        int n;
        int start_updates;
        sb = new();
        sender_eager = 1'b0;
        hold_asks = 0;
        holds_done = 0;
        config_changes = 0;
        rst_n <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= REG_BRIGHTNESS;
        wr_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.mode <= MODE_TICK;
        item_ch.raw_segments <= 1'b0;
        item_ch.digit_addr <= '0;
        item_ch.force_blank <= 1'b0;
        item_ch.digit_0 <= '0;
        item_ch.digit_1 <= '0;
        item_ch.digit_2 <= '0;
        item_ch.digit_3 <= '0;
        item_ch.decimal_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle ticks, a first update at the reset settings, maybe a request while busy.
        send(random_tick());
        send(random_tick());
        run_update(make_req(MODE_SINGLE, 1'b0, 3'd0, 1'b0, 32'h0000_0000, 14'd0), 1'b1, 1'b0);

        // Lowest brightness, no clock point: addresses, blanking, raw and out-of-range codes.
        reconfigure(3'd0, 1'b0);
        run_update(make_req(MODE_SINGLE, 1'b0, 3'd7, 1'b0, 32'h0000_000F, 14'd0), 1'b0, 1'b0);
        run_update(make_req(MODE_SINGLE, 1'b0, 3'd6, 1'b1, 32'h0000_0008, 14'd0), 1'b0, 1'b1);
        run_update(make_req(MODE_SINGLE, 1'b1, 3'd5, 1'b0, 32'h0000_00FF, 14'd0), 1'b0, 1'b0);
        run_update(make_req(MODE_SINGLE, 1'b0, 3'd2, 1'b0, 32'h0000_0010, 14'd0), 1'b0, 1'b0);
        run_update(make_req(MODE_DIGITS, 1'b0, 3'd0, 1'b0, 32'h0F0A_0900, 14'd0), 1'b0, 1'b0);
        run_update(make_req(MODE_DIGITS, 1'b1, 3'd0, 1'b0, 32'hAA55_FF00, 14'd0), 1'b0, 1'b0);
        run_update(make_req(MODE_DECIMAL, 1'b0, 3'd0, 1'b0, 32'h0, 14'd0), 1'b0, 1'b0);

        // Highest brightness with the clock point: decimal extremes and wrap above 9999.
        reconfigure(3'd7, 1'b1);
        run_update(make_req(MODE_DECIMAL, 1'b0, 3'd0, 1'b0, 32'h0, 14'd9999), 1'b0, 1'b0);
        run_update(make_req(MODE_DECIMAL, 1'b1, 3'd0, 1'b0, 32'h0, 14'h3FFF), 1'b0, 1'b0);
        run_update(make_req(MODE_DECIMAL, 1'b0, 3'd0, 1'b0, 32'h0, 14'd10000), 1'b0, 1'b0);
        run_update(make_req(MODE_DIGITS, 1'b0, 3'd0, 1'b0, 32'h0BFF_8010, 14'd0), 1'b0, 1'b0);
        run_update(make_req(MODE_SINGLE, 1'b1, 3'd1, 1'b1, 32'h0000_00FF, 14'd0), 1'b1, 1'b0);

        // Random updates with noise, idle ticks, a long result hold and config changes.
        start_updates = sb.updates;
        n = 0;
        while (sb.ticks + sb.updates + sb.ignored < 1000 || sb.updates - start_updates < 5)
        begin
            n++;
            if (n % 5 == 0)
                reconfigure(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            if (n == 2)
                drain();
            if (n == 3)
                hold_asks++;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send(random_tick());
            run_update(random_request(), $urandom_range(0, 3) == 0,
                       (n == 3) || ($urandom_range(0, 3) == 0));
        end

        // Wait for the last results, then a few more cycles for anything stray.
        item_ch.valid <= 1'b0;
        n = 0;
        while (sb.levels_due.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
        if (sb.levels_due.size() != 0)
            $display("%0d expected results never arrived", sb.levels_due.size());
        $display("Sent %0d display updates and %0d ticks; %0d requests dropped while busy.",
                 sb.updates, sb.ticks, sb.ignored);
        $display("Checked %0d results over %0d configuration settings, %0d mismatches.",
                 sb.checked, config_changes + 1, sb.mismatches);
        if (sb.mismatches == 0 && sb.levels_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
